// ----- src/fbc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the block convolution filter: widths, payload types and the
// control word that travels down the pipeline. No dependencies.
package fbc_pkg;

   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 16;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int RESULT_W  = 35;
   localparam int NUM_COEF  = 8;
   localparam int CSR_IDX_W = 4;
   localparam int COEF_IDX_W = $clog2(NUM_COEF);

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [RESULT_W-1:0] result_type;
   typedef logic [CSR_IDX_W-1:0]       csr_index_type;

   typedef struct packed {
      logic valid;
      logic last;
   } ctl_type;

endpackage

// ----- src/fbc_cell.sv -----
`timescale 1ns / 1ps
// One tap cell: holds one sample of the delay line, passes it to the next
// cell on each step and registers its coefficient product. Uses fbc_pkg.
module fbc_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic               adv,
   input  fbc_pkg::sample_type tap_in,
   input  fbc_pkg::coef_type   coef,
   output fbc_pkg::sample_type tap_out,
   output fbc_pkg::prod_type   prod
);
   import fbc_pkg::*;

   sample_type tap_ff;
   sample_type tap_in_d;
   prod_type   prod_ff;
   prod_type   prod_in;

   always_comb begin
      tap_in_d = step ? tap_in : tap_ff;
      prod_in  = adv ? coef * tap_ff : prod_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff <= '0;
      end else begin
         tap_ff <= tap_in_d;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign tap_out = tap_ff;
   assign prod    = prod_ff;

endmodule

// ----- src/fbc_sum_tree.sv -----
`timescale 1ns / 1ps
// Registered adder tree that sums the cell products in three stages and
// carries the control word alongside. Uses fbc_pkg.
module fbc_sum_tree (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  fbc_pkg::ctl_type  ctl_in,
   input  fbc_pkg::prod_type prods [fbc_pkg::NUM_COEF],
   output fbc_pkg::ctl_type  ctl_out,
   output fbc_pkg::result_type sum
);
   import fbc_pkg::*;

   localparam int N_A = NUM_COEF / 2;
   localparam int N_B = NUM_COEF / 4;

   result_type sa_ff [N_A];
   result_type sa_in [N_A];
   result_type sb_ff [N_B];
   result_type sb_in [N_B];
   result_type sc_ff;
   result_type sc_in;
   ctl_type    ca_ff, ca_in;
   ctl_type    cb_ff, cb_in;
   ctl_type    cc_ff, cc_in;

   always_comb begin
      for (int i = 0; i < N_A; i++) begin
         sa_in[i] = adv ? RESULT_W'(prods[2*i]) + RESULT_W'(prods[2*i+1]) : sa_ff[i];
      end
      for (int i = 0; i < N_B; i++) begin
         sb_in[i] = adv ? sa_ff[2*i] + sa_ff[2*i+1] : sb_ff[i];
      end
      sc_in = adv ? sb_ff[0] + sb_ff[1] : sc_ff;
      ca_in = adv ? ctl_in : ca_ff;
      cb_in = adv ? ca_ff : cb_ff;
      cc_in = adv ? cb_ff : cc_ff;
   end

   always_ff @(posedge clock) begin
      sa_ff <= sa_in;
      sb_ff <= sb_in;
      sc_ff <= sc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ca_ff <= '0;
         cb_ff <= '0;
         cc_ff <= '0;
      end else begin
         ca_ff <= ca_in;
         cb_ff <= cb_in;
         cc_ff <= cc_in;
      end
   end

   assign ctl_out = cc_ff;
   assign sum     = sc_ff;

endmodule

// ----- src/fir_block_convolution.sv -----
`timescale 1ns / 1ps
// Top level of the block convolution filter: coefficient registers, tail
// sequencing and the chain of tap cells feeding the adder tree.
// Depends on fbc_pkg, fbc_cell and fbc_sum_tree.
//
// Usage:
//   Samples arrive on the req_ channel and results leave on the rsp_
//   channel; a transfer happens when valid is high and stall is low.
//   Coefficients are written on the csr_ channel (index 0 to 7, data is
//   signed Q1.15); indexes of 8 and above are ignored. Write them only
//   while no results are outstanding.
//   Each sample gives one 35-bit result. A sample with req_last_sample set
//   also gives TAPS-1 tail results, one per cycle unless the receiver stalls,
//   during which req_stall stays high; the final one carries rsp_last_result,
//   and the delay line is then empty for the next block.
//   Throughput is one sample per cycle unless a block tail or a receiver
//   stall holds req_stall high. A result passes the delay line, the product
//   register and the adder-tree stages on its way to rsp_valid. When the
//   receiver stalls a waiting result, the whole pipeline holds and req_stall
//   goes high in the same cycle.
//   Reset clears the coefficients, the delay line and all pending results.
module fir_block_convolution #(
   parameter int TAPS = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  fbc_pkg::sample_type      req_sample,
   input  logic                     req_last_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output fbc_pkg::result_type      rsp_result_value,
   output logic                     rsp_last_result,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  fbc_pkg::csr_index_type   csr_index,
   input  fbc_pkg::coef_type        csr_data
);
   import fbc_pkg::*;

   localparam int TAIL_W = (TAPS > 1) ? $clog2(TAPS) : 1;

   coef_type           coef_ff [NUM_COEF];
   logic [TAIL_W-1:0]  tail_cnt_ff, tail_cnt_in;
   ctl_type            ctl0_ff, ctl0_in;
   ctl_type            ctl1_ff, ctl1_in;
   ctl_type            ctl_out;
   logic               adv;
   logic               tail_busy;
   logic               accept;
   logic               step;
   logic               step_last;
   sample_type         step_sample;
   sample_type         taps [TAPS];
   prod_type           prods [NUM_COEF];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEF; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_valid && csr_index < CSR_IDX_W'(NUM_COEF)) begin
         coef_ff[csr_index[COEF_IDX_W-1:0]] <= csr_data;
      end
   end

   always_comb begin
      tail_busy = (tail_cnt_ff != '0);
      adv       = !rsp_valid || !rsp_stall;
      req_stall = !adv || tail_busy;
      accept    = req_valid && !req_stall;
      step      = accept || (adv && tail_busy);
      step_sample = tail_busy ? '0 : req_sample;
      if (tail_busy) begin
         step_last = (tail_cnt_ff == TAIL_W'(1));
      end else begin
         step_last = accept && req_last_sample && (TAPS == 1);
      end
      tail_cnt_in = tail_cnt_ff;
      if (tail_busy && adv) begin
         tail_cnt_in = tail_cnt_ff - TAIL_W'(1);
      end else if (accept && req_last_sample) begin
         tail_cnt_in = TAIL_W'(TAPS - 1);
      end
      ctl0_in = ctl0_ff;
      ctl1_in = ctl1_ff;
      if (adv) begin
         ctl0_in.valid = step;
         ctl0_in.last  = step_last;
         ctl1_in       = ctl0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_cnt_ff <= '0;
         ctl0_ff     <= '0;
         ctl1_ff     <= '0;
      end else begin
         tail_cnt_ff <= tail_cnt_in;
         ctl0_ff     <= ctl0_in;
         ctl1_ff     <= ctl1_in;
      end
   end

   for (genvar k = 0; k < NUM_COEF; k++) begin : g_cell
      if (k < TAPS) begin : g_used
         fbc_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .step    (step),
            .adv     (adv),
            .tap_in  ((k == 0) ? step_sample : taps[(k == 0) ? 0 : k - 1]),
            .coef    (coef_ff[k]),
            .tap_out (taps[k]),
            .prod    (prods[k])
         );
      end else begin : g_unused
         assign prods[k] = '0;
      end
   end

   fbc_sum_tree u_tree (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .ctl_in  (ctl1_ff),
      .prods   (prods),
      .ctl_out (ctl_out),
      .sum     (rsp_result_value)
   );

   assign rsp_valid       = ctl_out.valid;
   assign rsp_last_result = ctl_out.last;

endmodule

// ----- src/fbc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the block convolution filter, bound to the top
// level. Depends only on the top level's ports.
module fbc_checker #(
   parameter int TAPS = 8
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_last_sample,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [34:0] rsp_result_value,
   input logic        rsp_last_result
);

   // A stalled result keeps its value until its transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value)
         && $stable(rsp_last_result))
      else $error("stalled result changed");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The tail of a block holds off the next sample.
   a_tail_stall: assert property (@(posedge clock) disable iff (reset)
      (TAPS > 1) && req_valid && !req_stall && req_last_sample |=> req_stall)
      else $error("sample taken during block tail");

   // With the receiver not stalling, a sample's result shows on rsp_valid.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall |=> rsp_valid)
      else $error("result missing after pipeline latency");

endmodule

bind fir_block_convolution fbc_checker #(.TAPS(TAPS)) u_fbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_last_sample  (req_last_sample),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_value (rsp_result_value),
   .rsp_last_result  (rsp_last_result)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fir_block_convolution: a directed table of samples and
// coefficient writes, then random sample blocks under random idling and stalls.
// Results are checked against a local convolution model; depends on fbc_pkg and the RTL.
module testbench;
   import fbc_pkg::*;

   localparam int TAPS = 8;
   localparam int DIRECTED_ROWS = 42;
   localparam int HOLD_CYCLES = 80;

   typedef enum logic {ROW_COEF, ROW_SAMPLE} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type index;
      sample_type    value;
      logic          last;
      logic          known;
      result_type    known_value;
   } stim_row_type;

   typedef struct packed {
      result_type value;
      logic       last;
   } conv_output_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   sample_type    req_sample = '0;
   logic          req_last_sample = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   result_type    rsp_result_value;
   logic          rsp_last_result;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = '0;
   coef_type      csr_data = '0;

   coef_type        coef_regs [NUM_COEF] = '{default: '0};
   sample_type      history [NUM_COEF-1] = '{default: '0};
   conv_output_type expected_outputs [$];
   stim_row_type    directed_rows [DIRECTED_ROWS];
   int              failures = 0;
   int              gap_max = 6;
   int              stall_max = 6;
   int              stall_left = 0;
   logic            backpressure_arm = 1'b0;
   int              backpressure_left = 0;

   fir_block_convolution #(
      .TAPS(TAPS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic result_type tap_sum(input sample_type x);
      longint acc;
      acc = longint'(coef_regs[0]) * longint'(x);
      for (int k = 1; k < TAPS; k++) begin
         acc += longint'(coef_regs[k]) * longint'(history[k-1]);
      end
      for (int k = TAPS - 2; k >= 1; k--) begin
         history[k] = history[k-1];
      end
      history[0] = x;
      return result_type'(acc);
   endfunction

   function automatic void append_expected(input conv_output_type entry);
      expected_outputs = {expected_outputs, entry};
   endfunction

   function automatic void convolve_sample(input sample_type x, input logic last,
                                           input logic known, input result_type known_value);
      conv_output_type entry;
      entry.value = tap_sum(x);
      entry.last = last && (TAPS == 1);
      if (known) begin
         entry.value = known_value;
      end
      append_expected(entry);
      if (last) begin
         for (int t = 1; t < TAPS; t++) begin
            entry.value = tap_sum('0);
            entry.last = (t == TAPS - 1);
            append_expected(entry);
         end
         foreach (history[i]) begin
            history[i] = '0;
         end
      end
   endfunction

   function automatic sample_type pick_word();
      case ($urandom_range(0, 7))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return '0;
         3: return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic offer_sample(input sample_type x, input logic last,
                               input logic known, input result_type known_value);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= x;
      req_last_sample <= last;
      do @(posedge clock); while (req_stall);
      convolve_sample(x, last, known, known_value);
   endtask

   task automatic write_coef(input csr_index_type idx, input coef_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx < NUM_COEF) begin
         coef_regs[idx[COEF_IDX_W-1:0]] = data;
      end
      @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (backpressure_arm) begin
         backpressure_left <= HOLD_CYCLES;
         backpressure_arm <= 1'b0;
      end else if (backpressure_left != 0) begin
         backpressure_left <= backpressure_left - 1;
      end
   end

   always @(posedge clock) begin
      conv_output_type head;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outputs.size() == 0) begin
               failures++;
               $display("%0t: unexpected result transfer, expected none, got value %0d last %b",
                        $time, rsp_result_value, rsp_last_result);
            end else begin
               head = expected_outputs.pop_front();
               if (rsp_result_value !== head.value) begin
                  failures++;
                  $display("%0t: result_value expected %0d, got %0d",
                           $time, head.value, rsp_result_value);
               end
               if (rsp_last_result !== head.last) begin
                  failures++;
                  $display("%0t: last_result expected %b, got %b",
                           $time, head.last, rsp_last_result);
               end
            end
            stall_left = $urandom_range(0, stall_max);
         end else if (stall_left != 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0) || (backpressure_left != 0);
      end
   end

   initial begin
      int cut;
      int len;
      int sent;
      directed_rows = '{
         '{ROW_SAMPLE, 4'd0,  16'sh7fff, 1'b0, 1'b1, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b1, 1'b1, 35'sd0},
         '{ROW_COEF,   4'd0,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh7fff, 1'b0, 1'b1, 35'sd1073676289},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b1, -35'sd1073709056},
         '{ROW_COEF,   4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd1,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd2,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd3,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd4,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd5,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd6,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd7,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b1, 1'b1, 35'sd8589934592},
         '{ROW_COEF,   4'd8,  16'sd12345, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd15, 16'shffff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd0,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd1,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd2,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd3,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd4,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd5,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd6,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_COEF,   4'd7,  16'sh7fff, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh8000, 1'b1, 1'b1, -35'sd8589672448},
         '{ROW_SAMPLE, 4'd0,  16'sh0000, 1'b1, 1'b1, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'sh0001, 1'b0, 1'b0, 35'sd0},
         '{ROW_SAMPLE, 4'd0,  16'shffff, 1'b1, 1'b0, 35'sd0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_COEF) begin
            drain_results();
            write_coef(directed_rows[i].index, directed_rows[i].value);
         end else begin
            offer_sample(directed_rows[i].value, directed_rows[i].last,
                         directed_rows[i].known, directed_rows[i].known_value);
         end
      end

      // Each phase loads new random coefficients, then streams whole blocks of random samples.
      for (int phase = 0; phase < 6; phase++) begin
         drain_results();
         gap_max = (phase % 2 == 1) ? 0 : 6;
         stall_max = (phase == 1 || phase == 2) ? 0 : 6;
         cut = (phase == 1 || phase == 4) ? $urandom_range(1, TAPS - 1) : NUM_COEF;
         for (int r = 0; r < NUM_COEF; r++) begin
            write_coef(csr_index_type'(r), (r < cut) ? pick_word() : coef_type'(0));
         end
         if ($urandom_range(0, 1) == 1) begin
            write_coef(csr_index_type'($urandom_range(NUM_COEF, 15)), coef_type'($urandom));
         end
         if (phase == 3) begin
            backpressure_arm <= 1'b1;
         end
         sent = 0;
         while (sent < 10) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
               offer_sample(pick_word(), i == len - 1, 1'b0, '0);
               sent++;
            end
         end
      end

      drain_results();
      if (failures == 0) begin
         $display("fir_block_convolution: match");
      end else begin
         $display("fir_block_convolution: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("fir_block_convolution: mismatch");
      $finish;
   end

endmodule

// ----- fir_block_convolution.f -----
src/fbc_pkg.sv
src/fbc_cell.sv
src/fbc_sum_tree.sv
src/fir_block_convolution.sv
src/fbc_checker.sv
tb/sv/testbench.sv
